### design/hp4_pkg.sv
`default_nettype none

package hp4_pkg;

    // Coefficient format: unsigned Q2.30 in a 32-bit register.
    localparam int COEF_BITS = 32;
    localparam int COEF_FRAC = 30;
    localparam int COEF_HALF = 16;

    // Headroom kept above the sample range inside the integrator state.
    localparam int HEAD_BITS = 4;

    // Configuration register map.
    localparam int NUM_REGS  = 5;
    localparam int REG_IDX_W = 3;

    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_COEF_FIRST_A  = 3'd0;
    localparam t_reg_idx REG_COEF_FIRST_B  = 3'd1;
    localparam t_reg_idx REG_COEF_SECOND_A = 3'd2;
    localparam t_reg_idx REG_COEF_SECOND_B = 3'd3;
    localparam t_reg_idx REG_OUTPUT_GAIN   = 3'd4;

    // Control handed from one cell of the chain to the next.
    typedef struct packed {
        logic en;
        logic valid;
    } t_stage_ctl;

endpackage

`default_nettype wire

### design/fourth_order_highpass_filter_top.sv
// An accepted input beat passes the difference registers of both section cells, then the output cell's two registers.
// Throughput: one sample per cycle, sustained, while the output side takes beats.
// The rate is set by the integrator feedback loop inside each section cell.
// Reset (synchronous, active low) clears all integrators, all coefficient
// registers and all valid flags, so every output beat is zero until the gain is written.
`default_nettype none

// Fourth-order high-pass filter built as a chain of cells. The first two
// cells are identical second-order sections; each one holds its own pair of
// integrators, forms the difference of its input and both integrators,
// updates the integrators in the same cycle and hands the difference on to
// its neighbor. The last cell scales the second difference by the output
// gain, rounds it back to the sample grid and saturates it.
//
// Flow control: the whole chain advances together. It holds only when a
// finished beat sits in the output register and the downstream side
// stalls. While it holds, the input is stalled as well, even if some cells
// of the chain carry no beat at that moment. An empty output register never
// holds the chain, so beats can follow each other with no gap.
module fourth_order_highpass_filter_top #(
    parameter int SAMPLE_BITS = 24,
    parameter int STATE_BITS  = 40
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,

    input  wire logic                                 i_cfg_we,
    input  wire hp4_pkg::t_reg_idx                    i_cfg_index,
    input  wire logic        [hp4_pkg::COEF_BITS-1:0] i_cfg_data,

    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]        i_sample_in,

    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic signed      [SAMPLE_BITS-1:0]        o_sample_out
);

    localparam int XW   = STATE_BITS + 3;
    localparam int FRAC = STATE_BITS - SAMPLE_BITS - hp4_pkg::HEAD_BITS;

    // Coefficient registers, all unsigned Q2.30.
    logic [hp4_pkg::COEF_BITS-1:0] r_coef_first_a;
    logic [hp4_pkg::COEF_BITS-1:0] r_coef_first_b;
    logic [hp4_pkg::COEF_BITS-1:0] r_coef_second_a;
    logic [hp4_pkg::COEF_BITS-1:0] r_coef_second_b;
    logic [hp4_pkg::COEF_BITS-1:0] r_output_gain;

    logic                 w_advance;
    logic signed [XW-1:0] w_s;
    logic                 w_valid_x1;
    logic signed [XW-1:0] w_x1;
    logic                 w_valid_x2;
    logic signed [XW-1:0] w_x2;

    hp4_pkg::t_stage_ctl w_ctl_in;
    hp4_pkg::t_stage_ctl w_ctl_x1;
    hp4_pkg::t_stage_ctl w_ctl_x2;

    // Writes to an index beyond the register map are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_first_a  <= '0;
            r_coef_first_b  <= '0;
            r_coef_second_a <= '0;
            r_coef_second_b <= '0;
            r_output_gain   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hp4_pkg::REG_COEF_FIRST_A:  r_coef_first_a  <= i_cfg_data;
                hp4_pkg::REG_COEF_FIRST_B:  r_coef_first_b  <= i_cfg_data;
                hp4_pkg::REG_COEF_SECOND_A: r_coef_second_a <= i_cfg_data;
                hp4_pkg::REG_COEF_SECOND_B: r_coef_second_b <= i_cfg_data;
                hp4_pkg::REG_OUTPUT_GAIN:   r_output_gain   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The chain moves unless the output register holds a beat that is stalled.
    assign w_advance  = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_advance;

    // The sample enters the state format with FRAC fraction bits below it.
    assign w_s = XW'($signed({i_sample_in, {FRAC{1'b0}}}));

    assign w_ctl_in = '{en: w_advance, valid: i_in_valid};
    assign w_ctl_x1 = '{en: w_advance, valid: w_valid_x1};
    assign w_ctl_x2 = '{en: w_advance, valid: w_valid_x2};

    hp4_sect #(.STATE_BITS(STATE_BITS)) u_sect_first (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl_in),
        .i_x      (w_s),
        .i_coef_a (r_coef_first_a),
        .i_coef_b (r_coef_first_b),
        .o_valid  (w_valid_x1),
        .o_x      (w_x1)
    );

    hp4_sect #(.STATE_BITS(STATE_BITS)) u_sect_second (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl_x1),
        .i_x      (w_x1),
        .i_coef_a (r_coef_second_a),
        .i_coef_b (r_coef_second_b),
        .o_valid  (w_valid_x2),
        .o_x      (w_x2)
    );

    hp4_gain #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .STATE_BITS  (STATE_BITS)
    ) u_gain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl_x2),
        .i_x      (w_x2),
        .i_gain   (r_output_gain),
        .o_valid  (o_out_valid),
        .o_sample (o_sample_out)
    );

endmodule

`default_nettype wire

### design/hp4_cmul.sv
`default_nettype none

// Signed value times an unsigned Q2.30 coefficient, rounded to nearest with
// ties toward plus infinity. The product is formed from two 16-bit halves
// of the coefficient.
module hp4_cmul #(
    parameter int AW = 40
) (
    input  wire logic signed [AW-1:0]                 i_a,
    input  wire logic        [hp4_pkg::COEF_BITS-1:0] i_c,
    output logic signed      [AW+2:0]                 o_p
);

    localparam int PW = AW + 34;
    localparam int HW = hp4_pkg::COEF_HALF;

    logic signed [PW-1:0] w_a;
    logic signed [PW-1:0] w_hi;
    logic signed [PW-1:0] w_lo;
    logic signed [PW-1:0] w_sum;
    logic signed [PW-1:0] w_rnd;

    always_comb begin
        w_a   = PW'(i_a);
        w_hi  = w_a * $signed({{(PW-HW){1'b0}}, i_c[hp4_pkg::COEF_BITS-1:HW]});
        w_lo  = w_a * $signed({{(PW-HW){1'b0}}, i_c[HW-1:0]});
        w_rnd = $signed({{(PW-hp4_pkg::COEF_FRAC){1'b0}},
                         1'b1, {(hp4_pkg::COEF_FRAC-1){1'b0}}});
        w_sum = (w_hi <<< HW) + w_lo + w_rnd;
    end

    assign o_p = w_sum[hp4_pkg::COEF_FRAC +: AW+3];

endmodule

`default_nettype wire

### design/hp4_sect.sv
`default_nettype none

// One second-order section: two integrators and the difference that feeds
// the first integrator and the next cell; the second integrator is fed from the first.
module hp4_sect #(
    parameter int STATE_BITS = 40
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire hp4_pkg::t_stage_ctl                  i_ctl,
    input  wire logic signed [STATE_BITS+2:0]         i_x,
    input  wire logic        [hp4_pkg::COEF_BITS-1:0] i_coef_a,
    input  wire logic        [hp4_pkg::COEF_BITS-1:0] i_coef_b,
    output logic                                      o_valid,
    output logic signed      [STATE_BITS+2:0]         o_x
);

    localparam int XW   = STATE_BITS + 3;
    localparam int SUMW = STATE_BITS + 7;

    logic signed [STATE_BITS-1:0] r_integ_a;
    logic signed [STATE_BITS-1:0] r_integ_b;
    logic signed [XW-1:0]         r_x;
    logic                         r_valid;

    logic signed [XW-1:0]         w_x;
    logic signed [STATE_BITS+2:0] w_pb;
    logic signed [XW+2:0]         w_pa;
    logic signed [SUMW-1:0]       w_sum_a;
    logic signed [SUMW-1:0]       w_sum_b;
    logic signed [STATE_BITS-1:0] n_integ_a;
    logic signed [STATE_BITS-1:0] n_integ_b;

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [SUMW-1:0] v
    );
        logic [SUMW-STATE_BITS:0] top;
        top = v[SUMW-1:STATE_BITS-1];
        if ((&top) || !(|top)) begin
            sat_state = v[STATE_BITS-1:0];
        end else if (v[SUMW-1]) begin
            sat_state = {1'b1, {(STATE_BITS-1){1'b0}}};
        end else begin
            sat_state = {1'b0, {(STATE_BITS-1){1'b1}}};
        end
    endfunction

    assign w_x = i_x - XW'(r_integ_a) - XW'(r_integ_b);

    hp4_cmul #(.AW(STATE_BITS)) u_cmul_b (
        .i_a (r_integ_a),
        .i_c (i_coef_b),
        .o_p (w_pb)
    );

    hp4_cmul #(.AW(XW)) u_cmul_a (
        .i_a (w_x),
        .i_c (i_coef_a),
        .o_p (w_pa)
    );

    always_comb begin
        w_sum_b   = SUMW'(r_integ_b) + SUMW'(w_pb);
        w_sum_a   = SUMW'(r_integ_a) + SUMW'(w_pa);
        n_integ_b = sat_state(w_sum_b);
        n_integ_a = sat_state(w_sum_a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ_a <= '0;
            r_integ_b <= '0;
            r_valid   <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.valid;
            if (i_ctl.valid) begin
                r_integ_a <= n_integ_a;
                r_integ_b <= n_integ_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en && i_ctl.valid) begin
            r_x <= w_x;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;

endmodule

`default_nettype wire

### design/hp4_gain.sv
`default_nettype none

// Output cell: gain product in the first stage, rounding to the sample grid
// and saturation in the second.
module hp4_gain #(
    parameter int SAMPLE_BITS = 24,
    parameter int STATE_BITS  = 40
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire hp4_pkg::t_stage_ctl                  i_ctl,
    input  wire logic signed [STATE_BITS+2:0]         i_x,
    input  wire logic        [hp4_pkg::COEF_BITS-1:0] i_gain,
    output logic                                      o_valid,
    output logic signed      [SAMPLE_BITS-1:0]        o_sample
);

    localparam int XW   = STATE_BITS + 3;
    localparam int RW   = XW + 3;
    localparam int FRAC = STATE_BITS - SAMPLE_BITS - hp4_pkg::HEAD_BITS;

    logic signed [RW-1:0]          w_p;
    logic signed [RW-1:0]          r_y;
    logic                          r_valid_y;
    logic signed [RW:0]            w_rnd;
    logic signed [RW:0]            w_q;
    logic signed [SAMPLE_BITS-1:0] n_sample;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_valid;

    hp4_cmul #(.AW(XW)) u_cmul (
        .i_a (i_x),
        .i_c (i_gain),
        .o_p (w_p)
    );

    always_comb begin
        w_rnd = (RW+1)'(r_y) + $signed({{(RW+1-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}});
        w_q   = w_rnd >>> FRAC;
        if ((&w_q[RW:SAMPLE_BITS-1]) || !(|w_q[RW:SAMPLE_BITS-1])) begin
            n_sample = w_q[SAMPLE_BITS-1:0];
        end else if (w_q[RW]) begin
            n_sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            n_sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_y <= 1'b0;
            r_valid   <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid_y <= i_ctl.valid;
            r_valid   <= r_valid_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_y      <= w_p;
            r_sample <= n_sample;
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;

endmodule

`default_nettype wire
